// ===== rtl/tsi_pkg.sv =====
// Package for the timestamped sample interpolator: sizes, status codes and
// controller state encoding. No dependencies.
`default_nettype none
package tsi_pkg;
  localparam int SAMPLES_DEF      = 8;
  localparam int CHANNEL_BITS_DEF = 16;
  localparam int TIME_BITS        = 32;
  localparam int WEIGHT_BITS      = 16;
  localparam int NUM_CHAN         = 6;

  typedef enum logic [1:0] {
    STAT_INTERP = 2'd0,
    STAT_BEFORE = 2'd1,
    STAT_AFTER  = 2'd2,
    STAT_NOPAIR = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_EDGE, ST_SCAN, ST_DIV, ST_BLEND, ST_OUT
  } ctl_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;        // write the input sample into the current slot
    logic cap_query;   // latch the query and reset scan index
    logic read_next;   // advance the scan index and read the pair
    logic div_start;   // start the weight divider
    logic div_step;    // one divider iteration
    logic blend;       // compute the interpolated channels
    logic pick_first;  // select slot 0 for output
    logic pick_last;   // select last slot for output
    logic [1:0] status;
  } tsi_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic q_le_first;
    logic q_ge_last;
    logic pair_hit;
    logic scan_end;
    logic div_done;
  } tsi_stat_t;
endpackage
`default_nettype wire

// ===== rtl/tsi_ctrl.sv =====
// Controller state machine of the interpolator.
// Depends on tsi_pkg.
`default_nettype none
module tsi_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic              in_op,
  input  wire logic              out_free,
  input  wire tsi_pkg::tsi_stat_t st,
  output tsi_pkg::tsi_cmd_t      cmd,
  output logic                   in_ready,
  output logic                   res_valid
);
  import tsi_pkg::*;
  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (in_op) begin
            cmd.cap_query = 1'b1;
            state_nxt = ST_EDGE;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_EDGE: begin
        if (st.q_le_first) begin
          cmd.pick_first = 1'b1;
          cmd.status = STAT_BEFORE;
          state_nxt = ST_OUT;
        end else if (st.q_ge_last) begin
          cmd.pick_last = 1'b1;
          cmd.status = STAT_AFTER;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (st.pair_hit) begin
          cmd.div_start = 1'b1;
          state_nxt = ST_DIV;
        end else if (st.scan_end) begin
          cmd.pick_first = 1'b1;
          cmd.status = STAT_NOPAIR;
          state_nxt = ST_OUT;
        end else begin
          cmd.read_next = 1'b1;
        end
      end
      ST_DIV: begin
        if (st.div_done) state_nxt = ST_BLEND;
        else cmd.div_step = 1'b1;
      end
      ST_BLEND: begin
        cmd.blend = 1'b1;
        cmd.status = STAT_INTERP;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        res_valid = 1'b1;
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/tsi_datapath.sv =====
// Datapath of the interpolator: sample stores, scan, serial divider and blend.
// Depends on tsi_pkg.
`default_nettype none
module tsi_datapath #(
  parameter int SAMPLES      = tsi_pkg::SAMPLES_DEF,
  parameter int CHANNEL_BITS = tsi_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire tsi_pkg::tsi_cmd_t                      cmd,
  input  wire logic [tsi_pkg::NUM_CHAN*CHANNEL_BITS-1:0] in_chan,
  input  wire logic [tsi_pkg::TIME_BITS-1:0]          in_stime,
  input  wire logic [tsi_pkg::TIME_BITS-1:0]          in_rtime,
  input  wire logic [tsi_pkg::TIME_BITS-1:0]          in_qtime,
  output tsi_pkg::tsi_stat_t                          st,
  output logic [tsi_pkg::NUM_CHAN*CHANNEL_BITS-1:0]   res_chan,
  output logic [tsi_pkg::TIME_BITS-1:0]               res_time,
  output logic [1:0]                                  res_status
);
  import tsi_pkg::*;
  localparam int IW = $clog2(SAMPLES);
  localparam int CB = CHANNEL_BITS;
  localparam int DB = CB + 1;
  localparam int PB = DB + WEIGHT_BITS + 1;
  localparam int DW = TIME_BITS + WEIGHT_BITS;
  localparam int CW = $clog2(WEIGHT_BITS + 1);
  localparam logic [IW-1:0] LAST = IW'(SAMPLES - 1);

  logic [NUM_CHAN*CB-1:0] chan_r [SAMPLES];
  logic [TIME_BITS-1:0]   time_r [SAMPLES];
  logic [IW-1:0]          pos_r, idx_r;
  logic [TIME_BITS-1:0]   sbase_r, rbase_r, q_r;
  logic [TIME_BITS-1:0]   rem_r, den_r;
  logic [WEIGHT_BITS-1:0] w_r;
  logic [CW-1:0]          cnt_r;
  logic [NUM_CHAN*CB-1:0] res_chan_r;
  logic [TIME_BITS-1:0]   res_time_r;
  logic [1:0]             res_status_r;

  logic [TIME_BITS-1:0] sb_use, rb_use, t1, t2;
  logic [TIME_BITS:0]   rem_sh;

  assign sb_use = (pos_r == '0) ? in_stime : sbase_r;
  assign rb_use = (pos_r == '0) ? in_rtime : rbase_r;
  assign t1 = time_r[idx_r];
  assign t2 = time_r[idx_r + IW'(1)];
  assign rem_sh = {rem_r, 1'b0};

  assign st.q_le_first = $signed(q_r) <= $signed(time_r[0]);
  assign st.q_ge_last  = $signed(q_r) >= $signed(time_r[LAST]);
  assign st.pair_hit   = ($signed(t1) <= $signed(q_r)) && ($signed(t2) > $signed(q_r));
  assign st.scan_end   = (idx_r == LAST - IW'(1));
  assign st.div_done   = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      sbase_r <= '0;
      rbase_r <= '0;
      for (int i = 0; i < SAMPLES; i++) begin
        chan_r[i] <= '0;
        time_r[i] <= '0;
      end
    end else if (cmd.load) begin
      sbase_r <= sb_use;
      rbase_r <= rb_use;
      chan_r[pos_r] <= in_chan;
      time_r[pos_r] <= rb_use + (in_stime - sb_use);
      pos_r <= (pos_r == LAST) ? '0 : pos_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_query) begin
      q_r   <= in_qtime;
      idx_r <= '0;
    end else if (cmd.read_next) begin
      idx_r <= idx_r + IW'(1);
    end
    if (cmd.div_start) begin
      // Remainder starts at q - t1 (< span); each step yields one weight bit.
      rem_r <= q_r - t1;
      den_r <= t2 - t1;
      w_r   <= '0;
      cnt_r <= CW'(WEIGHT_BITS);
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_r <= TIME_BITS'(rem_sh - {1'b0, den_r});
        w_r   <= {w_r[WEIGHT_BITS-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[TIME_BITS-1:0];
        w_r   <= {w_r[WEIGHT_BITS-2:0], 1'b0};
      end
      cnt_r <= cnt_r - CW'(1);
    end
    if (cmd.pick_first) begin
      res_chan_r   <= chan_r[0];
      res_time_r   <= time_r[0];
      res_status_r <= cmd.status;
    end else if (cmd.pick_last) begin
      res_chan_r   <= chan_r[LAST];
      res_time_r   <= time_r[LAST];
      res_status_r <= cmd.status;
    end else if (cmd.blend) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        logic signed [DB-1:0] a, b, d;
        logic signed [PB-1:0] p;
        a = DB'($signed(chan_r[idx_r][c*CB +: CB]));
        b = DB'($signed(chan_r[idx_r + IW'(1)][c*CB +: CB]));
        d = b - a;
        p = PB'(d) * $signed({1'b0, w_r}) + PB'(32'sd32768);
        res_chan_r[c*CB +: CB] <= CB'(a + DB'(p >>> WEIGHT_BITS));
      end
      res_time_r   <= q_r;
      res_status_r <= cmd.status;
    end
  end

  assign res_chan   = res_chan_r;
  assign res_time   = res_time_r;
  assign res_status = res_status_r;
endmodule
`default_nettype wire

// ===== rtl/timestamped_sample_interpolator_unit.sv =====
// Top level of the timestamped sample interpolator.
// Depends on tsi_pkg, tsi_ctrl and tsi_datapath.
// A load transfer (operation 0) stores one six-channel sample and gives no
// result; the slot time is rebased to the receiver clock of the packet's first
// sample. A query transfer (operation 1) gives one result: the first or last
// sample when the query lies outside the stored span, the first sample when
// no bracketing pair is found, otherwise the linear interpolation of the pair.
// A query at a span edge passes through accept, edge compare and result. An
// interior query adds the bracket scan (one pair per cycle), the bit-serial
// Q0.16 weight divider and the blend. Items are handled one at a time; the
// result register holds until the result transfer completes.
`default_nettype none
module timestamped_sample_interpolator_unit #(
  parameter int SAMPLES      = tsi_pkg::SAMPLES_DEF,
  parameter int CHANNEL_BITS = tsi_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // Fields from bit 0: accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
  // sample_time, receive_time, query_time.
  input  wire logic [((6*CHANNEL_BITS+3*32)+7)/8*8-1:0] in_tdata,
  input  wire logic in_tuser,  // operation
  output logic      out_tvalid,
  input  wire logic out_tready,
  // Fields from bit 0: out_accel_x..z, out_gyro_x..z, out_time, query_status.
  output logic [((6*CHANNEL_BITS+34)+7)/8*8-1:0] out_tdata
);
  import tsi_pkg::*;
  localparam int CHW = NUM_CHAN * CHANNEL_BITS;
  localparam int OW  = (CHW + TIME_BITS + 2 + 7) / 8 * 8;

  tsi_cmd_t  cmd;
  tsi_stat_t st;
  logic [CHW-1:0]       res_chan;
  logic [TIME_BITS-1:0] res_time;
  logic [1:0]           res_status;
  logic in_fire;

  assign in_fire = in_tvalid && in_tready;

  tsi_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_op(in_tuser),
    .out_free(out_tready), .st(st), .cmd(cmd),
    .in_ready(in_tready), .res_valid(out_tvalid)
  );

  tsi_datapath #(.SAMPLES(SAMPLES), .CHANNEL_BITS(CHANNEL_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_chan(in_tdata[CHW-1:0]),
    .in_stime(in_tdata[CHW +: TIME_BITS]),
    .in_rtime(in_tdata[CHW+TIME_BITS +: TIME_BITS]),
    .in_qtime(in_tdata[CHW+2*TIME_BITS +: TIME_BITS]),
    .st(st), .res_chan(res_chan), .res_time(res_time), .res_status(res_status)
  );

  assign out_tdata = OW'({res_status, res_time, res_chan});
endmodule
`default_nettype wire
